@@ src/assert_macros.svh @@
// assertion macros for the quadratic fit block
// depends on nothing; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ src/qlsf_pkg.sv @@
// shared constants, types and solve microprogram for the quadratic fit
// depends on nothing
package qlsf_pkg;

    localparam int MAX_POINTS = 256;
    localparam int X_BITS     = 12;
    localparam int Y_BITS     = 24;
    localparam int CNT_W      = 9;
    localparam int LIMB_W     = 32;
    localparam int LIMBS      = 8;
    localparam int WIDE_W     = LIMB_W * LIMBS;
    localparam int LIMB_IDX_W = $clog2(LIMBS);
    localparam int FRAC_SHIFT = 24;
    localparam int SLOT_W     = 5;
    localparam int RAM_AW     = SLOT_W + LIMB_IDX_W;
    localparam int RAM_DEPTH  = 1 << RAM_AW;
    localparam int MUL_IN_W   = LIMB_W + 1;
    localparam int MUL_OUT_W  = 2 * MUL_IN_W;
    localparam int COL_W      = 2 * LIMB_W + 8;
    localparam int COEF_W     = 64;
    localparam int DIV_CNT_W  = $clog2(WIDE_W);

    localparam int SUM_X_W   = 21;
    localparam int SUM_X2_W  = 33;
    localparam int SUM_X3_W  = 45;
    localparam int SUM_X4_W  = 57;
    localparam int SUM_Y_W   = 33;
    localparam int SUM_XY_W  = 45;
    localparam int SUM_X2Y_W = 57;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 208;
    localparam int OUT_USER_W = 2;

    localparam int PROG_LEN = 47;
    localparam int PC_W     = 6;

    // slots of the limb memory, eight limbs each
    localparam logic [SLOT_W-1:0] SL_S00 = 5'd0;
    localparam logic [SLOT_W-1:0] SL_S10 = 5'd1;
    localparam logic [SLOT_W-1:0] SL_S20 = 5'd2;
    localparam logic [SLOT_W-1:0] SL_S30 = 5'd3;
    localparam logic [SLOT_W-1:0] SL_S40 = 5'd4;
    localparam logic [SLOT_W-1:0] SL_S01 = 5'd5;
    localparam logic [SLOT_W-1:0] SL_S11 = 5'd6;
    localparam logic [SLOT_W-1:0] SL_S21 = 5'd7;
    localparam logic [SLOT_W-1:0] SL_M0  = 5'd8;
    localparam logic [SLOT_W-1:0] SL_M1  = 5'd9;
    localparam logic [SLOT_W-1:0] SL_M2  = 5'd10;
    localparam logic [SLOT_W-1:0] SL_DEN = 5'd11;
    localparam logic [SLOT_W-1:0] SL_NC  = 5'd12;
    localparam logic [SLOT_W-1:0] SL_NB  = 5'd13;
    localparam logic [SLOT_W-1:0] SL_NA  = 5'd14;
    localparam logic [SLOT_W-1:0] SL_T0  = 5'd15;
    localparam logic [SLOT_W-1:0] SL_T1  = 5'd16;
    localparam logic [SLOT_W-1:0] SL_T2  = 5'd17;
    localparam logic [SLOT_W-1:0] SL_X0  = 5'd18;
    localparam logic [SLOT_W-1:0] SL_X1  = 5'd19;
    localparam logic [SLOT_W-1:0] SL_X2  = 5'd20;

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_ADD = 2'd1,
        OP_SUB = 2'd2
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] d;
        logic [SLOT_W-1:0] a;
        logic [SLOT_W-1:0] b;
    } t_uop;

    typedef enum logic [13:0] {
        ST_IDLE  = 14'h0001,
        ST_ACC   = 14'h0002,
        ST_LOAD  = 14'h0004,
        ST_FETCH = 14'h0008,
        ST_MRD   = 14'h0010,
        ST_MWT   = 14'h0020,
        ST_MACC  = 14'h0040,
        ST_ARD   = 14'h0080,
        ST_AWT   = 14'h0100,
        ST_LRD   = 14'h0200,
        ST_LWT   = 14'h0400,
        ST_DGO   = 14'h0800,
        ST_DWAIT = 14'h1000,
        ST_FIN   = 14'h2000
    } t_state;

    function automatic t_uop mk(input t_op i_op, input logic [SLOT_W-1:0] i_d,
                                input logic [SLOT_W-1:0] i_a,
                                input logic [SLOT_W-1:0] i_b);
        t_uop u;
        u.op = i_op;
        u.d  = i_d;
        u.a  = i_a;
        u.b  = i_b;
        return u;
    endfunction

    // cramer solve: minors, determinant, then the three numerators
    function automatic t_uop prog_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            6'd0:  u = mk(OP_MUL, SL_T0, SL_S20, SL_S40);
            6'd1:  u = mk(OP_MUL, SL_T1, SL_S30, SL_S30);
            6'd2:  u = mk(OP_SUB, SL_M0, SL_T0, SL_T1);
            6'd3:  u = mk(OP_MUL, SL_T0, SL_S10, SL_S40);
            6'd4:  u = mk(OP_MUL, SL_T1, SL_S20, SL_S30);
            6'd5:  u = mk(OP_SUB, SL_M1, SL_T0, SL_T1);
            6'd6:  u = mk(OP_MUL, SL_T0, SL_S10, SL_S30);
            6'd7:  u = mk(OP_MUL, SL_T1, SL_S20, SL_S20);
            6'd8:  u = mk(OP_SUB, SL_M2, SL_T0, SL_T1);
            6'd9:  u = mk(OP_MUL, SL_T0, SL_S00, SL_M0);
            6'd10: u = mk(OP_MUL, SL_T1, SL_S10, SL_M1);
            6'd11: u = mk(OP_SUB, SL_T2, SL_T0, SL_T1);
            6'd12: u = mk(OP_MUL, SL_T0, SL_S20, SL_M2);
            6'd13: u = mk(OP_ADD, SL_DEN, SL_T2, SL_T0);
            6'd14: u = mk(OP_MUL, SL_T0, SL_S01, SL_M0);
            6'd15: u = mk(OP_MUL, SL_T1, SL_S11, SL_M1);
            6'd16: u = mk(OP_SUB, SL_T2, SL_T0, SL_T1);
            6'd17: u = mk(OP_MUL, SL_T0, SL_S21, SL_M2);
            6'd18: u = mk(OP_ADD, SL_NC, SL_T2, SL_T0);
            6'd19: u = mk(OP_MUL, SL_T0, SL_S11, SL_S40);
            6'd20: u = mk(OP_MUL, SL_T1, SL_S30, SL_S21);
            6'd21: u = mk(OP_SUB, SL_X0, SL_T0, SL_T1);
            6'd22: u = mk(OP_MUL, SL_T0, SL_S01, SL_S40);
            6'd23: u = mk(OP_MUL, SL_T1, SL_S21, SL_S20);
            6'd24: u = mk(OP_SUB, SL_X1, SL_T0, SL_T1);
            6'd25: u = mk(OP_MUL, SL_T0, SL_S01, SL_S30);
            6'd26: u = mk(OP_MUL, SL_T1, SL_S11, SL_S20);
            6'd27: u = mk(OP_SUB, SL_X2, SL_T0, SL_T1);
            6'd28: u = mk(OP_MUL, SL_T0, SL_S00, SL_X0);
            6'd29: u = mk(OP_MUL, SL_T1, SL_S10, SL_X1);
            6'd30: u = mk(OP_SUB, SL_T2, SL_T0, SL_T1);
            6'd31: u = mk(OP_MUL, SL_T0, SL_S20, SL_X2);
            6'd32: u = mk(OP_ADD, SL_NB, SL_T2, SL_T0);
            6'd33: u = mk(OP_MUL, SL_T0, SL_S20, SL_S21);
            6'd34: u = mk(OP_MUL, SL_T1, SL_S11, SL_S30);
            6'd35: u = mk(OP_SUB, SL_X0, SL_T0, SL_T1);
            6'd36: u = mk(OP_MUL, SL_T0, SL_S10, SL_S21);
            6'd37: u = mk(OP_MUL, SL_T1, SL_S01, SL_S30);
            6'd38: u = mk(OP_SUB, SL_X1, SL_T0, SL_T1);
            6'd39: u = mk(OP_MUL, SL_T0, SL_S10, SL_S11);
            6'd40: u = mk(OP_MUL, SL_T1, SL_S01, SL_S20);
            6'd41: u = mk(OP_SUB, SL_X2, SL_T0, SL_T1);
            6'd42: u = mk(OP_MUL, SL_T0, SL_S00, SL_X0);
            6'd43: u = mk(OP_MUL, SL_T1, SL_S10, SL_X1);
            6'd44: u = mk(OP_SUB, SL_T2, SL_T0, SL_T1);
            6'd45: u = mk(OP_MUL, SL_T0, SL_S20, SL_X2);
            6'd46: u = mk(OP_ADD, SL_NA, SL_T2, SL_T0);
            default: u = mk(OP_ADD, SL_T2, SL_T2, SL_T2);
        endcase
        return u;
    endfunction

endpackage

@@ src/qlsf_ram.sv @@
// generic simple ram: one write port, two registered read ports
// depends on nothing
module qlsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end
endmodule

@@ src/qlsf_div.sv @@
// restoring long divider, one quotient bit per cycle
// depends on qlsf_pkg
module qlsf_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [qlsf_pkg::WIDE_W-1:0]  i_num,
    input  logic [qlsf_pkg::WIDE_W-1:0]  i_den,
    output logic                         o_done,
    output logic [qlsf_pkg::WIDE_W-1:0]  o_quot
);
    import qlsf_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [WIDE_W-1:0]    r_n;
    logic [WIDE_W-1:0]    r_d;
    logic [WIDE_W-1:0]    r_rem;
    logic [WIDE_W-1:0]    r_q;
    logic [WIDE_W-1:0]    rem_sh;
    logic [WIDE_W-1:0]    n_rem;
    logic                 ge;

    always_comb begin
        rem_sh = {r_rem[WIDE_W-2:0], r_n[WIDE_W-1]};
        ge     = (rem_sh >= r_d);
        n_rem  = ge ? (rem_sh - r_d) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
                r_n    <= i_num;
                r_d    <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= {r_q[WIDE_W-2:0], ge};
                r_n   <= {r_n[WIDE_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

@@ src/quadratic_least_squares_fit.sv @@
// quadratic least-squares calibration fit, top level
// depends on qlsf_pkg, qlsf_ram, qlsf_div and assert_macros.svh
//
// usage
//   slave stream takes calibration points: tdata carries x_raw and y_value,
//   tlast marks the final point of a set. each kept point adds to seven running
//   sums through the shared 33x33 multiplier, with ready low while its products
//   are formed after the accept cycle; a dropped point adds nothing.
//   the last point starts the solve: sums go to the limb ram, a 47-step
//   microprogram runs cramer's rule on 32-bit limbs through the same multiplier
//   and a 32-bit adder, with 36 limb products in each of its 30 wide multiplies,
//   then the divider gives 256 quotient bits per coefficient, one per cycle.
//   master stream gives one result item per set: tdata carries coef_a, coef_b,
//   coef_c and points_used, tuser carries singular and points_dropped.
//   the result sits in an output register; while the receiver stalls, new
//   points are still accepted, but a finished solve waits for the register.
//   reset clears the sums, the point count and the dropped flag; the limb ram
//   needs no clearing since every slot is written before it is read.
`include "assert_macros.svh"
module quadratic_least_squares_fit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // x_raw [11:0], y_value [35:12], zero pad
    input  logic [qlsf_pkg::IN_DATA_W-1:0]     i_s_tdata,
    input  logic                               i_s_tlast,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // coef_a [63:0], coef_b [127:64], coef_c [191:128], points_used [200:192], pad
    output logic [qlsf_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // singular [0], points_dropped [1]
    output logic [qlsf_pkg::OUT_USER_W-1:0]    o_m_tuser
);
    import qlsf_pkg::*;

    t_state r_state;

    // accumulation state
    logic [CNT_W-1:0]     r_count;
    logic [SUM_X_W-1:0]   r_sx;
    logic [SUM_X2_W-1:0]  r_sx2;
    logic [SUM_X3_W-1:0]  r_sx3;
    logic [SUM_X4_W-1:0]  r_sx4;
    logic [SUM_Y_W-1:0]   r_sy;
    logic [SUM_XY_W-1:0]  r_sxy;
    logic [SUM_X2Y_W-1:0] r_sx2y;
    logic                 r_ovf;

    logic [X_BITS-1:0]         r_x;
    logic signed [Y_BITS-1:0]  r_y;
    logic                      r_last;
    logic [2*X_BITS-1:0]       r_x2;
    logic [2:0]                r_step;

    // shared multiplier
    logic signed [MUL_IN_W-1:0]  mul_a;
    logic signed [MUL_IN_W-1:0]  mul_b;
    logic signed [MUL_OUT_W-1:0] r_prod;

    // microprogram sequencer
    logic [PC_W-1:0]       r_pc;
    t_uop                  r_uop;
    logic [LIMB_IDX_W-1:0] r_k;
    logic [LIMB_IDX_W-1:0] r_i;
    logic [COL_W-1:0]      r_col;
    logic                  r_carry;
    logic [2:0]            r_slot;
    logic [COL_W-1:0]      col_sum;
    logic [LIMB_W:0]       add_sum;
    logic [63:0]           load_val;
    logic                  op_last;

    // limb ram
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [LIMB_W-1:0] ram_wdata;
    logic [RAM_AW-1:0] ram_raddr0;
    logic [RAM_AW-1:0] ram_raddr1;
    logic [LIMB_W-1:0] ram_rdata0;
    logic [LIMB_W-1:0] ram_rdata1;

    // divide stage
    logic [WIDE_W-1:0] r_num;
    logic [WIDE_W-1:0] r_den;
    logic [1:0]        r_cidx;
    logic              r_neg;
    logic              r_sing;
    logic [COEF_W-1:0] r_ca;
    logic [COEF_W-1:0] r_cb;
    logic [COEF_W-1:0] r_cc;
    logic [WIDE_W-1:0] num_sh;
    logic [WIDE_W-1:0] num_mag;
    logic [WIDE_W-1:0] den_mag;
    logic              div_start;
    logic              div_done;
    logic [WIDE_W-1:0] div_quot;
    logic [COEF_W-1:0] sat_val;
    logic              q_big;
    logic [COEF_W-1:0] q_mag;
    logic [SLOT_W-1:0] num_slot;

    // output register
    logic                  r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;
    logic [OUT_USER_W-1:0] r_ouser;

    logic in_acc;
    logic out_free;

    assign o_s_tready = (r_state == ST_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_ovalid || i_m_tready;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;
    assign op_last    = (r_pc == PC_W'(PROG_LEN - 1));

    // multiplier operands: point products while accumulating, limbs otherwise
    always_comb begin
        mul_a = $signed({1'b0, ram_rdata0});
        mul_b = $signed({1'b0, ram_rdata1});
        if (r_state == ST_ACC) begin
            case (r_step)
                3'd0: begin
                    mul_a = $signed(MUL_IN_W'(r_x));
                    mul_b = $signed(MUL_IN_W'(r_x));
                end
                3'd1: begin
                    mul_a = $signed(MUL_IN_W'(r_x));
                    mul_b = MUL_IN_W'(r_y);
                end
                3'd2: begin
                    mul_a = $signed(MUL_IN_W'(r_x2));
                    mul_b = $signed(MUL_IN_W'(r_x));
                end
                3'd3: begin
                    mul_a = $signed(MUL_IN_W'(r_x2));
                    mul_b = $signed(MUL_IN_W'(r_x2));
                end
                default: begin
                    mul_a = $signed(MUL_IN_W'(r_x2));
                    mul_b = MUL_IN_W'(r_y);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // sum chosen for the ram load, sign extended to 64 bits (the point count zero extended)
    always_comb begin
        case (r_slot)
            3'd0:    load_val = 64'(r_count);
            3'd1:    load_val = 64'($signed(r_sx));
            3'd2:    load_val = 64'($signed(r_sx2));
            3'd3:    load_val = 64'($signed(r_sx3));
            3'd4:    load_val = 64'($signed(r_sx4));
            3'd5:    load_val = 64'($signed(r_sy));
            3'd6:    load_val = 64'($signed(r_sxy));
            default: load_val = 64'($signed(r_sx2y));
        endcase
    end

    always_comb begin
        case (r_cidx)
            2'd0:    num_slot = SL_NA;
            2'd1:    num_slot = SL_NB;
            default: num_slot = SL_NC;
        endcase
    end

    assign col_sum = r_col + COL_W'(r_prod[2*LIMB_W-1:0]);
    assign add_sum = {1'b0, ram_rdata0}
                   + {1'b0, (r_uop.op == OP_SUB) ? ~ram_rdata1 : ram_rdata1}
                   + (LIMB_W + 1)'(r_carry);

    // limb ram port control
    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = {r_uop.d, r_k};
        ram_wdata  = add_sum[LIMB_W-1:0];
        ram_raddr0 = {r_uop.a, r_k};
        ram_raddr1 = {r_uop.b, r_k};
        case (r_state)
            ST_LOAD: begin
                ram_we    = 1'b1;
                ram_waddr = {SLOT_W'(r_slot), r_k};
                if (r_k == LIMB_IDX_W'(0)) begin
                    ram_wdata = load_val[31:0];
                end else if (r_k == LIMB_IDX_W'(1)) begin
                    ram_wdata = load_val[63:32];
                end else begin
                    ram_wdata = {LIMB_W{load_val[63]}};
                end
            end
            ST_MRD: begin
                ram_raddr0 = {r_uop.a, r_i};
                ram_raddr1 = {r_uop.b, LIMB_IDX_W'(r_k - r_i)};
            end
            ST_MACC: begin
                ram_we    = (r_i == r_k);
                ram_wdata = col_sum[LIMB_W-1:0];
            end
            ST_AWT: begin
                ram_we = 1'b1;
            end
            ST_LRD: begin
                ram_raddr0 = {num_slot, r_k};
                ram_raddr1 = {SL_DEN, r_k};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    qlsf_ram #(
        .WIDTH (LIMB_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (ram_waddr),
        .i_wdata  (ram_wdata),
        .i_raddr0 (ram_raddr0),
        .i_raddr1 (ram_raddr1),
        .o_rdata0 (ram_rdata0),
        .o_rdata1 (ram_rdata1)
    );

    // magnitudes for the divider: numerator scaled by 2^24 first
    always_comb begin
        num_sh  = r_num << FRAC_SHIFT;
        num_mag = num_sh[WIDE_W-1] ? (~num_sh + WIDE_W'(1)) : num_sh;
        den_mag = r_den[WIDE_W-1] ? (~r_den + WIDE_W'(1)) : r_den;
    end

    assign div_start = (r_state == ST_DGO) && (r_den != '0);

    qlsf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_mag),
        .i_den   (den_mag),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // truncated quotient saturated to signed 64 bits
    always_comb begin
        q_big = |div_quot[WIDE_W-1:COEF_W];
        q_mag = div_quot[COEF_W-1:0];
        if (r_neg) begin
            if (q_big || (q_mag > 64'h8000_0000_0000_0000)) begin
                sat_val = 64'h8000_0000_0000_0000;
            end else begin
                sat_val = 64'(0) - q_mag;
            end
        end else begin
            if (q_big || q_mag[COEF_W-1]) begin
                sat_val = 64'h7FFF_FFFF_FFFF_FFFF;
            end else begin
                sat_val = q_mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_sx     <= '0;
            r_sx2    <= '0;
            r_sx3    <= '0;
            r_sx4    <= '0;
            r_sy     <= '0;
            r_sxy    <= '0;
            r_sx2y   <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
            r_pc     <= '0;
        end else begin
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_x    <= i_s_tdata[X_BITS-1:0];
                        r_y    <= i_s_tdata[12 +: Y_BITS];
                        r_last <= i_s_tlast;
                        r_step <= 3'd0;
                        r_slot <= 3'd0;
                        r_k    <= '0;
                        if (r_count < CNT_W'(MAX_POINTS)) begin
                            r_state <= ST_ACC;
                        end else begin
                            // set is full: drop the point, a last one still solves
                            r_ovf <= 1'b1;
                            if (i_s_tlast) begin
                                r_state <= ST_LOAD;
                            end
                        end
                    end
                end
                ST_ACC: begin
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd0: begin
                            r_sx    <= r_sx + SUM_X_W'(r_x);
                            r_sy    <= r_sy + SUM_Y_W'(r_y);
                            r_count <= r_count + CNT_W'(1);
                        end
                        3'd1: begin
                            r_x2  <= r_prod[2*X_BITS-1:0];
                            r_sx2 <= r_sx2 + r_prod[SUM_X2_W-1:0];
                        end
                        3'd2: r_sxy <= r_sxy + r_prod[SUM_XY_W-1:0];
                        3'd3: r_sx3 <= r_sx3 + r_prod[SUM_X3_W-1:0];
                        3'd4: r_sx4 <= r_sx4 + r_prod[SUM_X4_W-1:0];
                        default: begin
                            r_sx2y  <= r_sx2y + r_prod[SUM_X2Y_W-1:0];
                            r_state <= r_last ? ST_LOAD : ST_IDLE;
                        end
                    endcase
                end
                ST_LOAD: begin
                    r_k <= r_k + LIMB_IDX_W'(1);
                    if (r_k == LIMB_IDX_W'(LIMBS - 1)) begin
                        r_slot <= r_slot + 3'd1;
                        if (r_slot == 3'd7) begin
                            r_pc    <= '0;
                            r_state <= ST_FETCH;
                        end
                    end
                end
                ST_FETCH: begin
                    r_uop   <= prog_rom(r_pc);
                    r_k     <= '0;
                    r_i     <= '0;
                    r_col   <= '0;
                    r_carry <= (prog_rom(r_pc).op == OP_SUB);
                    r_state <= (prog_rom(r_pc).op == OP_MUL) ? ST_MRD : ST_ARD;
                end
                ST_MRD: r_state <= ST_MWT;
                ST_MWT: r_state <= ST_MACC;
                ST_MACC: begin
                    if (r_i == r_k) begin
                        // column done: limb written, carry moves up
                        r_col <= COL_W'(col_sum[COL_W-1:LIMB_W]);
                        r_i   <= '0;
                        if (r_k == LIMB_IDX_W'(LIMBS - 1)) begin
                            r_k  <= '0;
                            r_pc <= r_pc + PC_W'(1);
                            if (op_last) begin
                                r_cidx  <= 2'd0;
                                r_state <= ST_LRD;
                            end else begin
                                r_state <= ST_FETCH;
                            end
                        end else begin
                            r_k     <= r_k + LIMB_IDX_W'(1);
                            r_state <= ST_MRD;
                        end
                    end else begin
                        r_col   <= col_sum;
                        r_i     <= r_i + LIMB_IDX_W'(1);
                        r_state <= ST_MRD;
                    end
                end
                ST_ARD: r_state <= ST_AWT;
                ST_AWT: begin
                    r_carry <= add_sum[LIMB_W];
                    if (r_k == LIMB_IDX_W'(LIMBS - 1)) begin
                        r_k  <= '0;
                        r_pc <= r_pc + PC_W'(1);
                        if (op_last) begin
                            r_cidx  <= 2'd0;
                            r_state <= ST_LRD;
                        end else begin
                            r_state <= ST_FETCH;
                        end
                    end else begin
                        r_k     <= r_k + LIMB_IDX_W'(1);
                        r_state <= ST_ARD;
                    end
                end
                ST_LRD: r_state <= ST_LWT;
                ST_LWT: begin
                    r_num <= {ram_rdata0, r_num[WIDE_W-1:LIMB_W]};
                    r_den <= {ram_rdata1, r_den[WIDE_W-1:LIMB_W]};
                    if (r_k == LIMB_IDX_W'(LIMBS - 1)) begin
                        r_k     <= '0;
                        r_state <= ST_DGO;
                    end else begin
                        r_k     <= r_k + LIMB_IDX_W'(1);
                        r_state <= ST_LRD;
                    end
                end
                ST_DGO: begin
                    r_neg  <= r_num[WIDE_W-1] ^ r_den[WIDE_W-1];
                    r_sing <= (r_den == '0);
                    if (r_den == '0) begin
                        // singular system: coefficients forced to zero
                        r_ca    <= '0;
                        r_cb    <= '0;
                        r_cc    <= '0;
                        r_state <= ST_FIN;
                    end else begin
                        r_state <= ST_DWAIT;
                    end
                end
                ST_DWAIT: begin
                    if (div_done) begin
                        case (r_cidx)
                            2'd0:    r_ca <= sat_val;
                            2'd1:    r_cb <= sat_val;
                            default: r_cc <= sat_val;
                        endcase
                        if (r_cidx == 2'd2) begin
                            r_state <= ST_FIN;
                        end else begin
                            r_cidx  <= r_cidx + 2'd1;
                            r_state <= ST_LRD;
                        end
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= OUT_DATA_W'({r_count, r_cc, r_cb, r_ca});
                        r_ouser  <= {r_ovf, r_sing};
                        r_count  <= '0;
                        r_sx     <= '0;
                        r_sx2    <= '0;
                        r_sx3    <= '0;
                        r_sx4    <= '0;
                        r_sy     <= '0;
                        r_sxy    <= '0;
                        r_sx2y   <= '0;
                        r_ovf    <= 1'b0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // a point that fits in the set keeps the block busy for its products
    `ASSERT_NXT(a_busy_after_point, i_clk, i_rst_n,
        in_acc && (r_count < CNT_W'(MAX_POINTS)), !o_s_tready, "ready after kept point")
    // a singular result carries zero coefficients
    `ASSERT_IMP(a_singular_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0],
        o_m_tdata[3*COEF_W-1:0] == '0, "singular result with nonzero coefficients")
    // the divider never runs on a zero determinant
    `ASSERT_IMP(a_no_div_by_zero, i_clk, i_rst_n, r_state == ST_DWAIT,
        r_den != '0, "divide with zero determinant")

endmodule
